/* rtl/core/apg_pkg.sv */
// Shared types, constants and arithmetic helpers for the arc point generator.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none
package apg_pkg;

  localparam int COORD_W   = 18;
  localparam int DIFF_W    = 19;
  localparam int IDX_W     = 11;
  localparam int Q_FRAC    = 30;
  localparam int QUOT_W    = 32;
  localparam int TRIG_W    = 32;
  localparam int LEVEL_MIN = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TESS_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_MODE = 2'd1;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Odd Taylor terms of sin(x*pi/2) in Q30, lowest order first.
  localparam logic [30:0] SIN_COEF [6] = '{
    31'd1686629713, 31'd693598670, 31'd85569306,
    31'd5027000, 31'd172273, 31'd3864
  };

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic                      last_point;
    logic                      out_of_range;
  } side_t;

  // Q30 product, floored.
  function automatic logic [31:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b);
    return p[61:30];
  endfunction

  // One Horner step: coef - floor(x2 * t).
  function automatic logic [30:0] horner_step(input logic [30:0] x2, input logic [30:0] t,
                                              input logic [30:0] coef);
    logic [61:0] p;
    p = 62'(x2) * 62'(t);
    return coef - p[60:30];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/apg_div.sv */
// Bit-per-stage restoring divider: floor(index * 2^30 / level) modulo 2^32.
// Depends on apg_pkg.
`default_nettype none
module apg_div
  import apg_pkg::*;
#(
  parameter int LVL_W = 9
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [IDX_W-1:0]  idx,
  input  wire logic [LVL_W-1:0]  lvl,
  input  wire side_t             in_side,
  output logic                   out_valid,
  output logic [QUOT_W-1:0]      quo,
  output side_t                  out_side
);

  localparam int NS = IDX_W + Q_FRAC;

  logic [NS-1:0]    v;
  logic [IDX_W-1:0] num_r  [NS];
  logic [LVL_W-1:0] rem_r  [NS];
  logic [QUOT_W-1:0] quo_r [NS];
  logic [LVL_W-1:0] lvl_r  [NS];
  side_t            sd_r   [NS];

  logic [IDX_W-1:0]  num_s [NS];
  logic [LVL_W-1:0]  rem_s [NS];
  logic [QUOT_W-1:0] quo_s [NS];
  logic [LVL_W-1:0]  lvl_s [NS];
  side_t             sd_s  [NS];
  logic [LVL_W:0]    trial [NS];
  logic [LVL_W:0]    diff  [NS];
  logic              ge    [NS];

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        num_s[k] = idx;
        rem_s[k] = '0;
        quo_s[k] = '0;
        lvl_s[k] = lvl;
        sd_s[k]  = in_side;
      end else begin
        num_s[k] = num_r[k-1];
        rem_s[k] = rem_r[k-1];
        quo_s[k] = quo_r[k-1];
        lvl_s[k] = lvl_r[k-1];
        sd_s[k]  = sd_r[k-1];
      end
      // The dividend's low 30 bits are zero; they shift in behind the index.
      trial[k] = {rem_s[k], num_s[k][IDX_W-1]};
      diff[k]  = trial[k] - {1'b0, lvl_s[k]};
      ge[k]    = trial[k] >= {1'b0, lvl_s[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        num_r[k] <= {num_s[k][IDX_W-2:0], 1'b0};
        rem_r[k] <= ge[k] ? diff[k][LVL_W-1:0] : trial[k][LVL_W-1:0];
        quo_r[k] <= {quo_s[k][QUOT_W-2:0], ge[k]};
        lvl_r[k] <= lvl_s[k];
        sd_r[k]  <= sd_s[k];
      end
    end
  end

  assign out_valid = v[NS-1];
  assign quo       = quo_r[NS-1];
  assign out_side  = sd_r[NS-1];

endmodule
`default_nettype wire

/* rtl/core/apg_sin.sv */
// Pipelined Q30 sine and cosine of a quarter-turn fraction, quadrant applied.
// Depends on apg_pkg.
`default_nettype none
module apg_sin
  import apg_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [Q_FRAC-1:0]        frac,
  input  wire quad_t                    quad,
  input  wire side_t                    in_side,
  output logic                          out_valid,
  output logic signed [TRIG_W-1:0]      cos_v,
  output logic signed [TRIG_W-1:0]      sin_v,
  output side_t                         out_side
);

  localparam int NH = 5;

  // Stage 1: arguments of both lanes.
  logic        v1, z1;
  logic [30:0] xs1, xc1;
  quad_t       q1;
  side_t       sd1;
  logic [31:0] sq_s, sq_c;
  // Stage 2: squares.
  logic        v2, z2;
  logic [30:0] xs2, xc2, x2s2, x2c2;
  quad_t       q2;
  side_t       sd2;
  // Horner stages.
  logic [NH-1:0] vh;
  logic [30:0] hxs [NH], hxc [NH], hx2s [NH], hx2c [NH], hts [NH], htc [NH];
  logic        hz  [NH];
  quad_t       hq  [NH];
  side_t       hsd [NH];
  logic [30:0] sxs [NH], sxc [NH], sx2s [NH], sx2c [NH], sts [NH], stc [NH];
  logic        sz  [NH];
  quad_t       sq  [NH];
  side_t       ssd [NH];
  // Final stage.
  logic        vo;
  logic [31:0] rs, rc;
  logic [30:0] s_cl, c_cl;
  logic signed [TRIG_W-1:0] sv, cv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vh <= '0;
      vo <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      vh <= {vh[NH-2:0], v2};
      vo <= vh[NH-1];
    end
  end

  assign sq_s = mul_q30(xs1, xs1);
  assign sq_c = mul_q30(xc1, xc1);

  always_ff @(posedge clk) begin
    if (en) begin
      xs1  <= {1'b0, frac};
      xc1  <= Q30_ONE - {1'b0, frac};
      z1   <= frac == '0;
      q1   <= quad;
      sd1  <= in_side;
      xs2  <= xs1;
      xc2  <= xc1;
      x2s2 <= sq_s[30:0];
      x2c2 <= sq_c[30:0];
      z2   <= z1;
      q2   <= q1;
      sd2  <= sd1;
    end
  end

  always_comb begin
    for (int j = 0; j < NH; j++) begin
      if (j == 0) begin
        sxs[j] = xs2;   sxc[j] = xc2;   sx2s[j] = x2s2; sx2c[j] = x2c2;
        sts[j] = SIN_COEF[5];           stc[j] = SIN_COEF[5];
        sz[j]  = z2;    sq[j]  = q2;    ssd[j] = sd2;
      end else begin
        sxs[j] = hxs[j-1];  sxc[j] = hxc[j-1];
        sx2s[j] = hx2s[j-1]; sx2c[j] = hx2c[j-1];
        sts[j] = hts[j-1];  stc[j] = htc[j-1];
        sz[j]  = hz[j-1];   sq[j]  = hq[j-1];  ssd[j] = hsd[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NH; j++) begin
        hxs[j]  <= sxs[j];
        hxc[j]  <= sxc[j];
        hx2s[j] <= sx2s[j];
        hx2c[j] <= sx2c[j];
        hts[j]  <= horner_step(sx2s[j], sts[j], SIN_COEF[NH-1-j]);
        htc[j]  <= horner_step(sx2c[j], stc[j], SIN_COEF[NH-1-j]);
        hz[j]   <= sz[j];
        hq[j]   <= sq[j];
        hsd[j]  <= ssd[j];
      end
    end
  end

  always_comb begin
    rs   = mul_q30(hxs[NH-1], hts[NH-1]);
    rc   = mul_q30(hxc[NH-1], htc[NH-1]);
    s_cl = (rs > {1'b0, Q30_ONE}) ? Q30_ONE : rs[30:0];
    c_cl = (rc > {1'b0, Q30_ONE}) ? Q30_ONE : rc[30:0];
    // A whole number of quarter turns is exact.
    if (hz[NH-1]) begin
      s_cl = '0;
      c_cl = Q30_ONE;
    end
    case (hq[NH-1])
      QUAD_0: begin
        cv = signed'({1'b0, c_cl});
        sv = signed'({1'b0, s_cl});
      end
      QUAD_1: begin
        cv = -signed'({1'b0, s_cl});
        sv = signed'({1'b0, c_cl});
      end
      QUAD_2: begin
        cv = -signed'({1'b0, c_cl});
        sv = -signed'({1'b0, s_cl});
      end
      default: begin
        cv = signed'({1'b0, s_cl});
        sv = -signed'({1'b0, c_cl});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_v    <= cv;
      sin_v    <= sv;
      out_side <= hsd[NH-1];
    end
  end

  assign out_valid = vo;

endmodule
`default_nettype wire

/* rtl/core/apg_rot.sv */
// Rotation of the start vector, rounding, center offset and saturation.
// Depends on apg_pkg.
`default_nettype none
module apg_rot
  import apg_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic signed [TRIG_W-1:0]  cos_v,
  input  wire logic signed [TRIG_W-1:0]  sin_v,
  input  wire side_t                     in_side,
  output logic                           out_valid,
  output logic signed [COORD_W-1:0]      point_x,
  output logic signed [COORD_W-1:0]      point_y,
  output logic                           last_point,
  output logic                           out_of_range
);

  localparam int PW = DIFF_W + TRIG_W;
  localparam int SW = PW + 1;
  localparam int RW = SW - Q_FRAC;
  localparam logic signed [SW-1:0] HALF = SW'(64'd1 << (Q_FRAC - 1));
  localparam logic signed [RW:0] SAT_MAX = (RW+1)'(131071);
  localparam logic signed [RW:0] SAT_MIN = -(RW+1)'(131072);

  logic v1, v2, v3;
  logic signed [PW-1:0] p_xc, p_ys, p_xs, p_yc;
  side_t sd1, sd2;
  logic signed [SW-1:0] ex, ey;
  logic signed [RW-1:0] rx, ry;
  logic signed [RW:0]   tx, ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Round to nearest, ties toward positive infinity.
  assign ex = SW'(p_xc) - SW'(p_ys) + HALF;
  assign ey = SW'(p_xs) + SW'(p_yc) + HALF;

  assign tx = (RW+1)'(sd2.cx) + (RW+1)'(rx);
  assign ty = (RW+1)'(sd2.cy) + (RW+1)'(ry);

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc <= PW'(in_side.dx) * PW'(cos_v);
      p_ys <= PW'(in_side.dy) * PW'(sin_v);
      p_xs <= PW'(in_side.dx) * PW'(sin_v);
      p_yc <= PW'(in_side.dy) * PW'(cos_v);
      sd1  <= in_side;
      rx   <= ex[SW-1:Q_FRAC];
      ry   <= ey[SW-1:Q_FRAC];
      sd2  <= sd1;
      point_x <= (tx > SAT_MAX) ? SAT_MAX[COORD_W-1:0] :
                 (tx < SAT_MIN) ? SAT_MIN[COORD_W-1:0] : tx[COORD_W-1:0];
      point_y <= (ty > SAT_MAX) ? SAT_MAX[COORD_W-1:0] :
                 (ty < SAT_MIN) ? SAT_MIN[COORD_W-1:0] : ty[COORD_W-1:0];
      last_point   <= sd2.last_point;
      out_of_range <= sd2.out_of_range;
    end
  end

  assign out_valid = v3;

endmodule
`default_nettype wire

/* rtl/core/arc_point_generator.sv */
// Arc point generator: one point per beat. Throughput is one beat per cycle; the 41-stage
// divider, 8-stage sine unit and 3-stage rotation advance together and hold only while
// the output beat is not taken.
// Synchronous reset empties the pipeline and sets tess_level to 10, circle_mode to 0.
// Depends on apg_pkg, apg_div, apg_sin and apg_rot.
`default_nettype none
module arc_point_generator
  import apg_pkg::*;
#(
  parameter int MAX_LEVEL = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // center_x[17:0], center_y[35:18], start_x[53:36], start_y[71:54], step_index[82:72]
  input  wire logic [87:0]           s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // point_x[17:0], point_y[35:18]
  output logic [39:0]                m_tdata,
  output logic                       m_tlast,
  // out_of_range[0]
  output logic [0:0]                 m_tuser,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [8:0]            cfg_data
);

  localparam int LVL_W = $clog2(MAX_LEVEL + 1);
  localparam int RUN_W = LVL_W + 2;

  logic [8:0] tess_level;
  logic       circle_mode;
  logic       en;

  logic signed [COORD_W-1:0] cx, cy, sx, sy;
  logic [IDX_W-1:0] idx;
  logic [LVL_W-1:0] lvl;
  logic [RUN_W-1:0] run;
  side_t in_side;

  logic        div_valid;
  logic [QUOT_W-1:0] quo;
  side_t       div_side;
  logic        sin_valid;
  logic signed [TRIG_W-1:0] cos_v, sin_v;
  side_t       sin_side;
  logic signed [COORD_W-1:0] px, py;
  logic        lp, oor;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tess_level  <= 9'd10;
      circle_mode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TESS_LEVEL:  tess_level  <= cfg_data;
        REG_CIRCLE_MODE: circle_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign cx  = s_tdata[17:0];
  assign cy  = s_tdata[35:18];
  assign sx  = s_tdata[53:36];
  assign sy  = s_tdata[71:54];
  assign idx = s_tdata[82:72];

  always_comb begin
    if (32'(tess_level) < LEVEL_MIN) begin
      lvl = LVL_W'(LEVEL_MIN);
    end else if (32'(tess_level) > MAX_LEVEL) begin
      lvl = LVL_W'(MAX_LEVEL);
    end else begin
      lvl = LVL_W'(tess_level);
    end
    run = circle_mode ? {lvl, 2'b00} : RUN_W'(lvl);
    in_side.cx = cx;
    in_side.cy = cy;
    in_side.dx = DIFF_W'(sx) - DIFF_W'(cx);
    in_side.dy = DIFF_W'(sy) - DIFF_W'(cy);
    in_side.last_point   = 32'(idx) == 32'(run);
    in_side.out_of_range = 32'(idx) > 32'(run);
  end

  apg_div #(.LVL_W(LVL_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .idx      (idx),
    .lvl      (lvl),
    .in_side  (in_side),
    .out_valid(div_valid),
    .quo      (quo),
    .out_side (div_side)
  );

  apg_sin u_sin (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (div_valid),
    .frac     (quo[Q_FRAC-1:0]),
    .quad     (quad_t'(quo[QUOT_W-1:Q_FRAC])),
    .in_side  (div_side),
    .out_valid(sin_valid),
    .cos_v    (cos_v),
    .sin_v    (sin_v),
    .out_side (sin_side)
  );

  apg_rot u_rot (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (sin_valid),
    .cos_v       (cos_v),
    .sin_v       (sin_v),
    .in_side     (sin_side),
    .out_valid   (m_tvalid),
    .point_x     (px),
    .point_y     (py),
    .last_point  (lp),
    .out_of_range(oor)
  );

  assign m_tdata = {4'b0000, py, px};
  assign m_tlast = lp;
  assign m_tuser = oor;

endmodule
`default_nettype wire

/* verif/arc_point_generator_test.sv */
// Self-checking testbench for arc_point_generator: drives center/start/index beats,
// predicts every generated point in its own model and checks each output beat.
// Depends on apg_pkg and the arc_point_generator RTL.
module arc_point_generator_test;
  import apg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PIPE_DRAIN  = 60;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [17:0] px;
    logic [17:0] py;
    logic        last;
    logic        oor;
  } arc_point_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [8:0]  cfg_data = '0;

  arc_point_generator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the register file.
  logic [8:0] level_copy = 9'd10;
  logic       circle_copy = 1'b0;

  arc_point_t pending_points[$];
  int  mismatches = 0;
  int  cycle_count = 0;
  bit  no_idle = 1'b0;
  bit  hold_request = 1'b0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** arc_point_generator: FAILED **");
      $finish;
    end
  end

  // sin(x * pi/2) in Q30 by the odd Horner polynomial, products floored.
  function automatic longint unsigned quarter_sine(input longint unsigned x);
    longint unsigned coef [6];
    longint unsigned x2, t, res;
    coef[0] = 64'd1686629713; coef[1] = 64'd693598670; coef[2] = 64'd85569306;
    coef[3] = 64'd5027000;    coef[4] = 64'd172273;    coef[5] = 64'd3864;
    if (x > 64'h4000_0000) x = 64'h4000_0000;
    x2 = (x * x) >> 30;
    t = coef[5];
    for (int k = 4; k >= 0; k--) t = coef[k] - ((x2 * t) >> 30);
    res = (x * t) >> 30;
    return (res > 64'h4000_0000) ? 64'h4000_0000 : res;
  endfunction

  function automatic logic [17:0] clamp_coord(input longint v);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[17:0];
  endfunction

  function automatic arc_point_t rotate_about_center(input logic signed [17:0] cx,
      input logic signed [17:0] cy, input logic signed [17:0] sx,
      input logic signed [17:0] sy, input logic [10:0] idx);
    arc_point_t pt;
    longint lvl, run, q, r, s, c, cs, sn, dx, dy, vx, vy;
    longint unsigned f;
    quad_t quad;
    lvl = longint'(level_copy);
    if (lvl < LEVEL_MIN) lvl = longint'(LEVEL_MIN);
    if (lvl > 256) lvl = 256;
    run = lvl * (circle_copy ? 4 : 1);
    dx = longint'(sx) - longint'(cx);
    dy = longint'(sy) - longint'(cy);
    q = idx / lvl;
    r = idx % lvl;
    if (r == 0) begin
      s = 0;
      c = 64'h4000_0000;
    end else begin
      f = (longint'(r) << 30) / lvl;
      s = quarter_sine(f);
      c = quarter_sine(64'h4000_0000 - f);
    end
    quad = quad_t'(q[1:0]);
    case (quad)
      QUAD_0: begin cs = c;  sn = s;  end
      QUAD_1: begin cs = -s; sn = c;  end
      QUAD_2: begin cs = -c; sn = -s; end
      default: begin cs = s; sn = -c; end
    endcase
    vx = (dx * cs - dy * sn + 64'sd536870912) >>> 30;
    vy = (dx * sn + dy * cs + 64'sd536870912) >>> 30;
    pt.px = clamp_coord(longint'(cx) + vx);
    pt.py = clamp_coord(longint'(cy) + vy);
    pt.last = (idx == run);
    pt.oor = (idx > run);
    return pt;
  endfunction

  task automatic send_point(input logic [17:0] cx, input logic [17:0] cy,
                            input logic [17:0] sx, input logic [17:0] sy,
                            input logic [10:0] idx);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, idx, sy, sx, cy, cx};
    do @(posedge clk); while (!s_tready);
    pending_points = {pending_points, rotate_about_center(cx, cy, sx, sy, idx)};
  endtask

  task automatic wait_drained;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TESS_LEVEL) level_copy = value;
    else if (idx == REG_CIRCLE_MODE) circle_copy = value[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [17:0] near_coord(input logic [17:0] base);
    return base + 18'($signed($urandom_range(0, 8191)) - 4096);
  endfunction

  // Run length under the current registers, for index choice.
  function automatic int run_length();
    int lvl;
    lvl = (level_copy < LEVEL_MIN) ? LEVEL_MIN : (level_copy > 256) ? 256 : level_copy;
    return lvl * (circle_copy ? 4 : 1);
  endfunction

  task automatic send_random_point();
    logic [17:0] cx, cy, sx, sy;
    logic [10:0] idx;
    int run;
    run = run_length();
    cx = 18'($urandom); cy = 18'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      sx = 18'($urandom); sy = 18'($urandom);
    end else begin
      cx = cx >>> 2; cy = cy >>> 2;
      sx = near_coord(cx); sy = near_coord(cy);
    end
    if ($urandom_range(0, 9) == 0) idx = 11'($urandom);
    else idx = 11'($urandom_range(0, (run > 2047) ? 2047 : run));
    send_point(cx, cy, sx, sy, idx);
  endtask

  // Receiving side: random stalls, a long hold-off on request.
  initial begin
    int stall;
    arc_point_t exp_pt;
    forever begin
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 17);
      end
      repeat (stall) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid || rst);
      if (pending_points.size() == 0) begin
        $error("output beat with no point expected");
        mismatches++;
      end else begin
        exp_pt = pending_points.pop_front();
        if (m_tdata[17:0] !== exp_pt.px) begin
          $error("point_x expected %0h actual %0h", exp_pt.px, m_tdata[17:0]);
          mismatches++;
        end
        if (m_tdata[35:18] !== exp_pt.py) begin
          $error("point_y expected %0h actual %0h", exp_pt.py, m_tdata[35:18]);
          mismatches++;
        end
        if (m_tdata[39:36] !== 4'b0) begin
          $error("tdata padding expected 0 actual %0h", m_tdata[39:36]);
          mismatches++;
        end
        if (m_tlast !== exp_pt.last) begin
          $error("last_point expected %0b actual %0b", exp_pt.last, m_tlast);
          mismatches++;
        end
        if (m_tuser[0] !== exp_pt.oor) begin
          $error("out_of_range expected %0b actual %0b", exp_pt.oor, m_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  task automatic test_directed_points();
    // Default level 10, one quarter turn, then indices past its end and extreme coordinates.
    send_point(18'd0, 18'd0, 18'd16384, 18'd0, 11'd0);
    send_point(18'd0, 18'd0, 18'd16384, 18'd0, 11'd1);
    send_point(18'd0, 18'd0, 18'd16384, 18'd0, 11'd5);
    send_point(18'd0, 18'd0, 18'd16384, 18'd0, 11'd9);
    send_point(18'd0, 18'd0, 18'd16384, 18'd0, 11'd10);
    send_point(18'd0, 18'd0, 18'd16384, 18'd0, 11'd11);
    send_point(18'd0, 18'd0, 18'd16384, 18'd0, 11'd20);
    send_point(18'd0, 18'd0, 18'd16384, 18'd0, 11'd35);
    send_point(18'd1000, 18'd2000, 18'd1000, 18'd2000, 11'd3);
    send_point(18'h1FFFF, 18'h1FFFF, 18'h20000, 18'h20000, 11'd7);
    send_point(18'h20000, 18'h20000, 18'h1FFFF, 18'h1FFFF, 11'd13);
    send_point(18'h1FFFF, 18'h20000, 18'h20000, 18'h1FFFF, 11'd1024);
    send_point(18'h20000, 18'h1FFFF, 18'h1FFFF, 18'h20000, 11'd2047);
    send_point(18'h3FFFF, 18'h2AAAA, 18'h15555, 18'h00001, 11'h555);
    send_point(18'h15555, 18'h3FFFF, 18'h2AAAA, 18'h3FFFE, 11'h2AA);
    send_point(18'h00100, 18'h3FF00, 18'h1F000, 18'h21000, 11'd15);
  endtask

  task automatic test_register_settings();
    logic [8:0] levels [7] = '{9'd0, 9'd9, 9'd10, 9'd256, 9'd257, 9'd511, 9'd37};
    int run;
    for (int n = 0; n < 7; n++) begin
      write_reg(REG_TESS_LEVEL, levels[n]);
      write_reg(REG_CIRCLE_MODE, 9'(n % 2));
      run = run_length();
      send_point(18'd0, 18'd0, 18'd20000, 18'd3000, 11'(run));
      send_point(18'd0, 18'd0, 18'd20000, 18'd3000, 11'(run + 1));
      send_point(18'd500, 18'd500, 18'd9000, 18'd400, 11'(run - 1));
      repeat (8) send_random_point();
    end
    write_reg(REG_CIRCLE_MODE, 9'h1FE);
  endtask

  task automatic test_random_points();
    for (int blk = 0; blk < 10; blk++) begin
      write_reg(REG_TESS_LEVEL, 9'($urandom_range(0, 511)));
      write_reg(REG_CIRCLE_MODE, 9'($urandom));
      no_idle = (blk == 3) || (blk == 7);
      repeat (54) send_random_point();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_output_hold_off();
    wait_drained();
    hold_request = 1'b1;
    repeat (120) begin
      no_idle = 1'b1;
      send_random_point();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_points();
    test_register_settings();
    test_random_points();
    test_output_hold_off();
    wait_drained();
    if (mismatches == 0) begin
      $display("** arc_point_generator: PASSED **");
    end else begin
      $display("** arc_point_generator: FAILED **");
    end
    $finish;
  end

endmodule
